// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/nfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator package
// Sizes, command and status codes, sequencer states and store control.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LIMIT_W = SLOT_W + 1;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = $clog2(SLOTS + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(SLOTS);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               alloc;
    logic [SLOT_W-1:0]  alloc_slot;
    logic [VALUE_W-1:0] wdata;
    logic               free_en;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  rd_slot;
  } store_ctl_t;

endpackage

// ----- hw/rtl/nfsa_if.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface nfsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [nfsa_pkg::SLOT_W-1:0] slot_index;
  logic [31:0]                 value_in;

  modport source (output valid, command, slot_index, value_in, input ready);
  modport sink (input valid, command, slot_index, value_in, output ready);
endinterface

interface nfsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [nfsa_pkg::SLOT_W-1:0] slot_out;
  logic [31:0]                 value_out;

  modport source (output valid, status, slot_out, value_out, input ready);
  modport sink (input valid, status, slot_out, value_out, output ready);
endinterface

interface nfsa_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] slots_in_use;

  modport source (output valid, slots_in_use, input ready);
  modport sink (input valid, slots_in_use, output ready);
endinterface

// ----- hw/rtl/next_fit_slot_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator core
// Slot table with next-fit insert, delete and get over valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: insert value_in, delete
//   slot_index, or get slot_index. rsp returns exactly one transaction per
//   request: status, slot_out and value_out. cfg writes slots_in_use, the
//   number of slots open to allocation; it is always ready. The user must
//   write it only while the core is idle; the core does not enforce this.
// Sequence (request accept to rsp valid, receiver ready): every command
//   passes DECODE and then RESP, which loads the output register; get
//   reads the store in READ between them, and insert scans in SCAN unless
//   no slot is open. The scan unit visits one slot per cycle starting at the
//   search cursor, so a busy table costs up to N slot visits, where N is the
//   active slot count. A full table reports full after visiting all N slots.
// Flow: one request in flight; req.ready rises together with rsp.valid, and
//   a new request is taken only once the last response has been loaded.
// Reset: all slots free, cursor at slot 0, slots_in_use 64, no response.
// Stall: a held response stays in the output register; the core finishes
//   the next request and then waits until the receiver takes the old one.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_core (
  input  logic        clk,
  input  logic        rst,
  nfsa_cfg_if.sink    cfg,
  nfsa_req_if.sink    req,
  nfsa_rsp_if.source  rsp
);

  nfsa_pkg::state_t state;
  nfsa_pkg::state_t state_next;

  // latched request
  logic [1:0]                   cmd_q;
  logic [nfsa_pkg::SLOT_W-1:0]  idx_q;
  logic [nfsa_pkg::VALUE_W-1:0] val_q;

  // configuration and allocation state
  logic [nfsa_pkg::LIMIT_W-1:0] limit;
  logic [nfsa_pkg::LIMIT_W-1:0] limit_eff;
  logic [nfsa_pkg::SLOT_W-1:0]  cursor;

  // pending result, then output register
  logic [1:0]                   res_status;
  logic [nfsa_pkg::SLOT_W-1:0]  res_slot;
  logic [nfsa_pkg::VALUE_W-1:0] res_value;
  logic                         out_valid;
  logic [1:0]                   out_status;
  logic [nfsa_pkg::SLOT_W-1:0]  out_slot;
  logic [nfsa_pkg::VALUE_W-1:0] out_value;

  // sequencer controls
  logic                 scan_start;
  logic                 scan_step;
  logic                 out_load;
  logic                 is_insert;
  logic                 no_slots;
  nfsa_pkg::store_ctl_t ctl;

  // scan and store status
  logic [nfsa_pkg::SLOT_W-1:0]  scan_pos;
  logic                         scan_last;
  logic                         free_at_pos;
  logic                         free_at_rd;
  logic [nfsa_pkg::VALUE_W-1:0] rd_data;

  // a limit above the table acts as the whole table
  assign limit_eff = (limit > nfsa_pkg::LIMIT_RESET) ? nfsa_pkg::LIMIT_RESET : limit;
  assign is_insert = cmd_q == nfsa_pkg::CMD_INSERT;
  assign no_slots  = limit_eff == '0;

  assign cfg.ready     = 1'b1;
  assign req.ready     = state == nfsa_pkg::ST_IDLE;
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.slot_out  = out_slot;
  assign rsp.value_out = out_value;

  nfsa_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (scan_start),
    .step   (scan_step),
    .limit  (limit_eff),
    .cursor (cursor),
    .pos    (scan_pos),
    .last   (scan_last)
  );

  nfsa_store u_store (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .free_at_alloc (free_at_pos),
    .free_at_rd    (free_at_rd),
    .rd_data       (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nfsa_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = nfsa_pkg::ST_DECODE;
        end
      end
      nfsa_pkg::ST_DECODE: begin
        if (is_insert && !no_slots) begin
          state_next = nfsa_pkg::ST_SCAN;
        end else if (cmd_q == nfsa_pkg::CMD_GET) begin
          state_next = nfsa_pkg::ST_READ;
        end else begin
          state_next = nfsa_pkg::ST_RESP;
        end
      end
      nfsa_pkg::ST_SCAN: begin
        if (free_at_pos || scan_last) begin
          state_next = nfsa_pkg::ST_RESP;
        end
      end
      nfsa_pkg::ST_READ: begin
        state_next = nfsa_pkg::ST_RESP;
      end
      nfsa_pkg::ST_RESP: begin
        if (!out_valid || rsp.ready) begin
          state_next = nfsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nfsa_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_start     = 1'b0;
    scan_step      = 1'b0;
    out_load       = 1'b0;
    ctl.alloc      = 1'b0;
    ctl.alloc_slot = scan_pos;
    ctl.wdata      = val_q;
    ctl.free_en    = 1'b0;
    ctl.free_slot  = idx_q;
    ctl.rd_slot    = idx_q;
    case (state)
      nfsa_pkg::ST_DECODE: begin
        scan_start  = is_insert;
        ctl.free_en = cmd_q == nfsa_pkg::CMD_DELETE;
      end
      nfsa_pkg::ST_SCAN: begin
        // claim the first free slot, else advance unless the lap is done
        ctl.alloc = free_at_pos;
        scan_step = !free_at_pos && !scan_last;
      end
      nfsa_pkg::ST_RESP: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register and search cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= nfsa_pkg::LIMIT_RESET;
      cursor <= '0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.slots_in_use;
      end
      if (ctl.alloc) begin
        cursor <= scan_pos;
      end
    end
  end

  // capture the request transaction
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q <= req.command;
      idx_q <= req.slot_index;
      val_q <= req.value_in;
    end
  end

  // build the result as the command resolves
  always_ff @(posedge clk) begin
    case (state)
      nfsa_pkg::ST_DECODE: begin
        res_value <= '0;
        if (is_insert && no_slots) begin
          res_status <= nfsa_pkg::STATUS_FULL;
          res_slot   <= '0;
        end else begin
          res_status <= nfsa_pkg::STATUS_OK;
          res_slot   <= idx_q;
        end
      end
      nfsa_pkg::ST_SCAN: begin
        if (free_at_pos) begin
          res_slot <= scan_pos;
        end else if (scan_last) begin
          res_status <= nfsa_pkg::STATUS_FULL;
          res_slot   <= '0;
        end
      end
      nfsa_pkg::ST_READ: begin
        if (free_at_rd) begin
          res_status <= nfsa_pkg::STATUS_EMPTY;
        end else begin
          res_value <= rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_value  <= res_value;
    end
  end

endmodule

// ----- hw/rtl/nfsa_scan.sv -----
// ----------------------------------------------------------------------------
// Next-fit scan unit
// Position register and step counter; one slot visited per step, wrapping.
// ----------------------------------------------------------------------------
module nfsa_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         step,
  input  logic [nfsa_pkg::LIMIT_W-1:0] limit,
  input  logic [nfsa_pkg::SLOT_W-1:0]  cursor,
  output logic [nfsa_pkg::SLOT_W-1:0]  pos,
  output logic                         last
);

  logic [nfsa_pkg::LIMIT_W-1:0] steps;
  logic [nfsa_pkg::LIMIT_W-1:0] pos_inc;
  logic [nfsa_pkg::LIMIT_W-1:0] cursor_ext;

  assign cursor_ext = nfsa_pkg::LIMIT_W'(cursor);
  assign pos_inc    = nfsa_pkg::LIMIT_W'(pos) + nfsa_pkg::LIMIT_W'(1);
  assign last       = (steps + nfsa_pkg::LIMIT_W'(1)) == limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      steps <= '0;
    end else if (start) begin
      // start at the cursor unless the limit has been lowered past it
      pos   <= (cursor_ext < limit) ? cursor : '0;
      steps <= '0;
    end else if (step) begin
      pos   <= (pos_inc < limit) ? pos_inc[nfsa_pkg::SLOT_W-1:0] : '0;
      steps <= steps + nfsa_pkg::LIMIT_W'(1);
    end
  end

endmodule

// ----- hw/rtl/nfsa_store.sv -----
// ----------------------------------------------------------------------------
// Slot store
// Free marks, value memory with registered read, and used-slot count.
// ----------------------------------------------------------------------------
module nfsa_store (
  input  logic                         clk,
  input  logic                         rst,
  input  nfsa_pkg::store_ctl_t         ctl,
  output logic                         free_at_alloc,
  output logic                         free_at_rd,
  output logic [nfsa_pkg::VALUE_W-1:0] rd_data
);

  logic [nfsa_pkg::SLOTS-1:0]   slot_free;
  logic [nfsa_pkg::VALUE_W-1:0] slot_data [nfsa_pkg::SLOTS];
  logic [nfsa_pkg::COUNT_W-1:0] used_count;

  assign free_at_alloc = slot_free[ctl.alloc_slot];
  assign free_at_rd    = slot_free[ctl.rd_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_free  <= '1;
      used_count <= '0;
    end else if (ctl.alloc) begin
      slot_free[ctl.alloc_slot] <= 1'b0;
      used_count <= used_count + nfsa_pkg::COUNT_W'(1);
    end else if (ctl.free_en && !slot_free[ctl.free_slot]) begin
      slot_free[ctl.free_slot] <= 1'b1;
      if (used_count != '0) begin
        used_count <= used_count - nfsa_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      slot_data[ctl.alloc_slot] <= ctl.wdata;
    end
    rd_data <= slot_data[ctl.rd_slot];
  end

endmodule

// ----- hw/rtl/nfsa_checker.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator port checker
// Port-level checks on request and response behavior, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [1:0]                  rsp_status,
  input logic [nfsa_pkg::SLOT_W-1:0] rsp_slot_out,
  input logic [31:0]                 rsp_value_out
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "request accepted while busy")
  `ASSERT_IMPLIES(a_full_zero, clk, rst, rsp_valid && rsp_status == nfsa_pkg::STATUS_FULL, rsp_slot_out == '0 && rsp_value_out == '0, "full response carries data")
  `ASSERT_IMPLIES(a_empty_zero, clk, rst, rsp_valid && rsp_status == nfsa_pkg::STATUS_EMPTY, rsp_value_out == '0, "empty response carries a value")

endmodule

bind next_fit_slot_allocator_core nfsa_checker u_nfsa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_slot_out  (rsp.slot_out),
  .rsp_value_out (rsp.value_out)
);

// ----- tb/slot_table_checker.sv -----
// ----------------------------------------------------------------------------
// Slot table checker
// Watches the cfg, req and rsp channels, keeps a shadow copy of the slot table
// and compares every response transaction field by field with its prediction.
// ----------------------------------------------------------------------------
module slot_table_checker
  import nfsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  nfsa_cfg_if         cfg,
  nfsa_req_if         req,
  nfsa_rsp_if         rsp,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } slot_result_t;

  // Shadow of the table; taken_count is kept for fidelity, not visible at the ports.
  logic [LIMIT_W-1:0] open_slots;
  bit                 slot_taken [SLOTS];
  logic [VALUE_W-1:0] slot_value [SLOTS];
  logic [SLOT_W-1:0]  scan_cursor;
  int unsigned        taken_count;

  slot_result_t       pending_results [$];

  function automatic slot_result_t apply_command(input logic [1:0]         cmd,
                                                 input logic [SLOT_W-1:0]  idx,
                                                 input logic [VALUE_W-1:0] val);
    slot_result_t r;
    int unsigned  span;
    int unsigned  pos;
    bit           found;
    r.status = STATUS_OK;
    r.slot   = idx;
    r.value  = '0;
    case (cmd)
      CMD_INSERT: begin
        // Limits above the table size act as the table size.
        span  = (open_slots > SLOTS) ? SLOTS : open_slots;
        pos   = (scan_cursor < span) ? scan_cursor : 0;
        found = 1'b0;
        for (int k = 0; k < span && !found; k++) begin
          if (!slot_taken[pos]) begin
            found = 1'b1;
          end else begin
            pos = (pos + 1 < span) ? pos + 1 : 0;
          end
        end
        if (found) begin
          slot_taken[pos] = 1'b1;
          slot_value[pos] = val;
          taken_count++;
          scan_cursor     = SLOT_W'(pos);
          r.slot          = SLOT_W'(pos);
        end else begin
          r.status = STATUS_FULL;
          r.slot   = '0;
        end
      end
      CMD_DELETE: begin
        if (slot_taken[idx]) begin
          slot_taken[idx] = 1'b0;
          if (taken_count > 0) taken_count--;
        end
      end
      CMD_GET: begin
        if (slot_taken[idx]) r.value = slot_value[idx];
        else r.status = STATUS_EMPTY;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t want;
    if (rst) begin
      open_slots  = LIMIT_RESET;
      scan_cursor = '0;
      taken_count = 0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_taken[i] = 1'b0;
        slot_value[i] = '0;
      end
      pending_results.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) open_slots = cfg.slots_in_use;
      // Retire before predicting: a response never belongs to the request
      // accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("response with no request outstanding: status %0d slot %0d value %h",
                 rsp.status, rsp.slot_out, rsp.value_out);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, rsp.slot_out);
            mismatches++;
          end
          if (rsp.value_out !== want.value) begin
            $error("value_out: expected %h, got %h", want.value, rsp.value_out);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_results.push_back(apply_command(req.command, req.slot_index, req.value_in));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Next-fit slot allocator testbench
// Drives directed and random insert, delete and get commands through several
// slot limits with random gaps and stalls; a checker predicts each response.
// ----------------------------------------------------------------------------
module tb;
  import nfsa_pkg::*;

  // Command code the core does not define; it must answer ok and change nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Idle cycles with no transaction on any channel before the run is abandoned.
  // Worst honest case: a long sender gap, a full 64-slot scan, a long stall.
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  localparam int unsigned RANDOM_PHASES    = 14;
  localparam int unsigned ITEMS_PER_PHASE  = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          quiet = 1'b0;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned outstanding;
  logic [6:0]  current_limit = 7'(LIMIT_RESET);

  nfsa_cfg_if cfg_ch ();
  nfsa_req_if req_ch ();
  nfsa_rsp_if rsp_ch ();

  next_fit_slot_allocator_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Receiver side: stall rsp.ready at random unless the phase runs quiet.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && $urandom_range(3, 0) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= pause_len();
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Reset the watchdog on any accepted transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL next_fit_slot_allocator_core");
        $finish;
      end
    end
  end

  // Present one request and hold it until the core takes it. Leave valid high
  // afterwards so a zero gap gives back-to-back transactions.
  task automatic send(input logic [1:0] cmd, input logic [SLOT_W-1:0] idx,
                      input logic [31:0] val);
    int unsigned gap;
    gap = quiet ? 0 : pause_len();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.slot_index <= idx;
    req_ch.value_in   <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and hold until every predicted response has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the slot limit with the core idle.
  task automatic set_limit(input logic [6:0] lim);
    drain();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.slots_in_use <= lim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid  <= 1'b0;
    current_limit = lim;
  endtask

  // The first phases hit the extremes: full table, no slots at all, an
  // out-of-range limit and a tiny one. Later phases favor small limits so the
  // table fills and the cursor wraps often.
  function automatic logic [6:0] pick_limit(input int unsigned phase);
    int unsigned roll;
    case (phase)
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd0;
      3: return 7'd127;
      4: return 7'd2;
      default: begin
        roll = $urandom_range(99, 0);
        if (roll < 50) return 7'($urandom_range(16, 1));
        if (roll < 85) return 7'($urandom_range(64, 1));
        return 7'($urandom_range(127, 65));
      end
    endcase
  endfunction

  // Random value with the all-zero and all-one corners mixed in.
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(19, 0);
    if (roll == 0) return 32'h0000_0000;
    if (roll == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  initial begin : stimulus
    int unsigned       roll;
    int unsigned       span;
    logic [SLOT_W-1:0] idx;
    logic [1:0]        cmd;

    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_INSERT;
    req_ch.slot_index   = '0;
    req_ch.value_in     = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.slots_in_use = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty reads, value corners, next-fit after a delete.
    send(CMD_GET,    6'd0,  32'h0);
    send(CMD_GET,    6'd63, 32'h0);
    send(CMD_INSERT, 6'd0,  32'h0000_0000);
    send(CMD_INSERT, 6'd0,  32'hFFFF_FFFF);
    send(CMD_INSERT, 6'd63, 32'hA5A5_A5A5);
    send(CMD_GET,    6'd1,  32'h0);
    send(CMD_GET,    6'd0,  32'h0);
    send(CMD_DELETE, 6'd1,  32'h0);
    send(CMD_DELETE, 6'd1,  32'hFFFF_FFFF);  // already free: no change
    send(CMD_GET,    6'd1,  32'h0);
    send(CMD_INSERT, 6'd1,  32'h5A5A_5A5A);  // must skip the hole behind the cursor
    send(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send(CMD_DELETE, 6'd63, 32'h0);

    // Small limit: wrap past the end, then a full table.
    set_limit(7'd4);
    send(CMD_INSERT, 6'd0,  32'h1234_5678);
    send(CMD_INSERT, 6'd0,  32'h8765_4321);

    // No slots open: inserts report full, storage stays reachable.
    set_limit(7'd0);
    send(CMD_INSERT, 6'd0,  32'hDEAD_BEEF);
    send(CMD_GET,    6'd3,  32'h0);
    send(CMD_DELETE, 6'd0,  32'h0);

    // Cursor now lies past the limit: the scan restarts at slot 0.
    set_limit(7'd1);
    send(CMD_INSERT, 6'd0,  32'hCAFE_F00D);

    // Limit above the table size acts as the table size.
    set_limit(7'd127);
    send(CMD_INSERT, 6'd0,  32'h0F0F_0F0F);
    send(CMD_GET,    6'd4,  32'h0);

    // Random phases: each starts with a fresh limit; every fourth runs with
    // no idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_limit(pick_limit(phase));
      quiet = (phase % 4 == 3);
      span  = (current_limit == 0 || current_limit > SLOTS) ? SLOTS : current_limit;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then hold the sender until the core has answered everything.
        if ($urandom_range(79, 0) == 0) drain();
        roll = $urandom_range(99, 0);
        if (roll < 45) cmd = CMD_INSERT;
        else if (roll < 75) cmd = CMD_DELETE;
        else if (roll < 97) cmd = CMD_GET;
        else cmd = CMD_UNUSED;
        // Aim mostly inside the open region, sometimes anywhere in the table.
        if ($urandom_range(4, 0) != 0) idx = SLOT_W'($urandom_range(span - 1, 0));
        else idx = SLOT_W'($urandom_range(SLOTS - 1, 0));
        send(cmd, idx, pick_value());
      end
    end

    quiet = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS next_fit_slot_allocator_core");
    end else begin
      $display("FAIL next_fit_slot_allocator_core");
    end
    $finish;
  end

endmodule

// ----- next_fit_slot_allocator_core.f -----
+incdir+hw/rtl
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_if.sv
hw/rtl/nfsa_scan.sv
hw/rtl/nfsa_store.sv
hw/rtl/next_fit_slot_allocator_core.sv
hw/rtl/nfsa_checker.sv
tb/slot_table_checker.sv
tb/tb.sv
